// ===== design/ddet_pkg.sv =====
// Shared types and constants of the device duration estimate table.
// Used by every module of the design; depends on nothing.
`default_nettype none

package ddet_pkg;

  // Table geometry
  localparam int unsigned MaxDevices = 256;
  localparam int unsigned IdW        = $clog2(MaxDevices);
  localparam int unsigned CapW       = IdW + 1;
  localparam int unsigned ValW       = 32;

  // Stream word widths
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 104;

  // Configuration port
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam logic [CapW-1:0] CapReset = CapW'(MaxDevices);

  // Request modes
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;
  localparam logic [1:0] ST_NOREG = 2'd3;

  // Control sequencer states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // One incoming request
  typedef struct packed {
    logic [ValW-1:0] duration_value;
    logic [IdW-1:0]  device_id;
    logic [1:0]      mode;
  } req_t;

  // One stored table entry
  typedef struct packed {
    logic [ValW-1:0] count;
    logic [ValW-1:0] initial_est;
    logic [ValW-1:0] estimate;
  } entry_t;

  // One result word
  typedef struct packed {
    logic [ValW-1:0] count_out;
    logic [ValW-1:0] initial_out;
    logic [ValW-1:0] estimate_out;
    logic [1:0]      status;
  } result_t;

  // Write-back command from the update logic to the table
  typedef struct packed {
    logic            wr_en;
    logic            set_active;
    logic [IdW-1:0]  addr;
    entry_t          entry;
  } wb_t;

endpackage : ddet_pkg

`default_nettype wire

// ===== design/ddet_table.sv =====
// Entry memory of the table: one 96-bit word per slot plus per-slot active bits.
// Depends on ddet_pkg. Read data is registered and appears in the cycle after the read strobe.
`default_nettype none

module ddet_table
  import ddet_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [IdW-1:0]   rd_addr,
  input  wire wb_t              wb,
  output entry_t                rd_entry,
  output logic                  rd_active
);

  entry_t                mem [MaxDevices];
  logic [MaxDevices-1:0] active_r;
  entry_t                rd_entry_r;
  logic                  rd_active_r;

  // Write port of the entry memory
  always_ff @(posedge clk) begin
    if (wb.wr_en) begin
      mem[wb.addr] <= wb.entry;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r  <= mem[rd_addr];
      rd_active_r <= active_r[rd_addr];
    end
  end

  // Active bits: cleared at reset, set by a successful add
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (wb.set_active) begin
      active_r[wb.addr] <= 1'b1;
    end
  end

  assign rd_entry  = rd_entry_r;
  assign rd_active = rd_active_r;

endmodule : ddet_table

`default_nettype wire

// ===== design/ddet_update.sv =====
// Decision and update logic: range check, add/update/lookup and the 1/8 average.
// Depends on ddet_pkg. Purely combinational between table read and write-back.
`default_nettype none

module ddet_update
  import ddet_pkg::*;
(
  input  wire req_t             req,
  input  wire logic [CapW-1:0]  capacity,
  input  wire entry_t           rd_entry,
  input  wire logic             rd_active,
  output wb_t                   wb,
  output result_t               result
);

  logic            in_range;
  logic [ValW+2:0] sum;
  entry_t          upd_entry;
  entry_t          add_entry;

  // Capacities above the table size still pass every 8-bit id
  assign in_range = {1'b0, req.device_id} < capacity;

  // new = (actual + 8*old - old) >> 3, kept exact in 35 bits
  assign sum = {3'b000, req.duration_value} + {rd_entry.estimate, 3'b000}
             - {3'b000, rd_entry.estimate};

  always_comb begin
    upd_entry             = rd_entry;
    upd_entry.estimate    = sum[ValW+2:3];
    if (rd_entry.count != '1) begin
      upd_entry.count = rd_entry.count + ValW'(1);
    end
    add_entry.estimate    = req.duration_value;
    add_entry.initial_est = req.duration_value;
    add_entry.count       = '0;
  end

  // Pick status, write-back and reported entry
  always_comb begin
    wb.wr_en          = 1'b0;
    wb.set_active     = 1'b0;
    wb.addr           = req.device_id;
    wb.entry          = upd_entry;
    result.status     = ST_OK;
    result.estimate_out = '0;
    result.initial_out  = '0;
    result.count_out    = '0;
    if (!in_range) begin
      result.status = ST_RANGE;
    end else if (req.mode == MODE_ADD) begin
      if (rd_active) begin
        result.status       = ST_DUP;
        result.estimate_out = rd_entry.estimate;
        result.initial_out  = rd_entry.initial_est;
        result.count_out    = rd_entry.count;
      end else begin
        wb.wr_en            = 1'b1;
        wb.set_active       = 1'b1;
        wb.entry            = add_entry;
        result.estimate_out = add_entry.estimate;
        result.initial_out  = add_entry.initial_est;
        result.count_out    = add_entry.count;
      end
    end else if (!rd_active) begin
      result.status = ST_NOREG;
    end else if (req.mode == MODE_UPDATE) begin
      wb.wr_en            = 1'b1;
      result.estimate_out = upd_entry.estimate;
      result.initial_out  = upd_entry.initial_est;
      result.count_out    = upd_entry.count;
    end else begin
      // lookup, and the unused fourth mode behaves the same
      result.estimate_out = rd_entry.estimate;
      result.initial_out  = rd_entry.initial_est;
      result.count_out    = rd_entry.count;
    end
  end

endmodule : ddet_update

`default_nettype wire

// ===== design/ddet_cfg.sv =====
// Configuration register file: the capacity register behind an APB-style port.
// Depends on ddet_pkg.
`default_nettype none

module ddet_cfg
  import ddet_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [CfgAddrW-1:0] cfg_paddr,
  input  wire logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0]      cfg_prdata,
  output logic                     cfg_pready,
  output logic [CapW-1:0]          capacity
);

  logic [CapW-1:0] capacity_r;
  logic [CapW-1:0] capacity_nxt;
  logic            hit;

  // Capacity lives at word index zero
  assign hit = (cfg_paddr[CfgAddrW-1:2] == '0);

  always_comb begin
    capacity_nxt = capacity_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && hit) begin
      capacity_nxt = cfg_pwdata[CapW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CapReset;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = hit ? {{(CfgDataW-CapW){1'b0}}, capacity_r} : '0;
  assign capacity   = capacity_r;

endmodule : ddet_cfg

`default_nettype wire

// ===== design/device_duration_estimate_table_top.sv =====
// Top level of the device duration estimate table: sequencer, output register.
// Depends on ddet_pkg, ddet_cfg, ddet_table and ddet_update.
//
// Use:
//   in_*  : request words {duration_value, device_id, mode}; one result word per
//           request on out_* {count_out, initial_out, estimate_out, status}.
//   cfg_* : APB-style port; capacity at byte address 0, written while idle.
// Order: the table is read as a request is accepted; in the execute state the
//   entry is updated and written back and the result word is loaded.
//   No new request is taken until the write-back of the last one is done,
//   so a request always reads the updated entry.
// Reset: active bits clear at once, capacity returns to 256, the output word
//   drops; no clearing pass is needed.
// Stall: a result word holds in the output register until taken; a new
//   request is still taken while it waits, if that word leaves in the
//   same cycle.
`default_nettype none

module device_duration_estimate_table_top
  import ddet_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // tdata: mode[1:0], device_id[9:2], duration_value[41:10], zero fill
  input  wire logic [InDataW-1:0]  in_tdata,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // tdata: status[1:0], estimate_out[33:2], initial_out[65:34],
  //        count_out[97:66], zero fill
  output logic [OutDataW-1:0]      out_tdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [CfgAddrW-1:0] cfg_paddr,
  input  wire logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0]      cfg_prdata,
  output logic                     cfg_pready
);

  localparam int unsigned ResW = $bits(result_t);

  state_t          state_r;
  state_t          state_nxt;
  req_t            req_r;
  req_t            in_req;
  logic            accept;
  logic            out_valid_r;
  logic            out_valid_nxt;
  result_t         out_res_r;
  logic [CapW-1:0] capacity;
  entry_t          rd_entry;
  logic            rd_active;
  wb_t             wb;
  wb_t             wb_gated;
  result_t         result;

  assign in_req = in_tdata[$bits(req_t)-1:0];

  // Take a request only when idle and the output slot is free by the next edge
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the request and load the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    if (state_r == S_EXEC) begin
      out_res_r <= result;
    end
  end

  // Write back only during the execute cycle
  always_comb begin
    wb_gated            = wb;
    wb_gated.wr_en      = wb.wr_en && (state_r == S_EXEC);
    wb_gated.set_active = wb.set_active && (state_r == S_EXEC);
  end

  ddet_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .capacity    (capacity)
  );

  ddet_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_addr   (in_req.device_id),
    .wb        (wb_gated),
    .rd_entry  (rd_entry),
    .rd_active (rd_active)
  );

  ddet_update u_update (
    .req       (req_r),
    .capacity  (capacity),
    .rd_entry  (rd_entry),
    .rd_active (rd_active),
    .wb        (wb),
    .result    (result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-ResW){1'b0}}, out_res_r};

endmodule : device_duration_estimate_table_top

`default_nettype wire

// ===== design/ddet_checker.sv =====
// Port-level checks of the device duration estimate table, bound to the top.
// Depends on ddet_pkg and device_duration_estimate_table_top.
`default_nettype none

module ddet_checker
  import ddet_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_tvalid,
  input wire logic                in_tready,
  input wire logic [OutDataW-1:0] out_tdata,
  input wire logic                out_tvalid,
  input wire logic                out_tready
);

  // A waiting word stays until it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // A stalled result blocks new requests
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("request taken while result word is stalled");

  // No request is taken in the cycle after a taken request
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken during execution");

  // Out-of-range and unregistered results carry zero entry fields
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ST_RANGE || out_tdata[1:0] == ST_NOREG)
    |-> out_tdata[OutDataW-1:2] == '0)
    else $error("rejected request reports entry data");

endmodule : ddet_checker

bind device_duration_estimate_table_top ddet_checker u_ddet_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire
